>>> rtl/lmpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_pkg: shared definitions for the 3x3 local maximum peak detector
// Widths, geometry limits, register indexes and the position record type.
// ----------------------------------------------------------------------------
package lmpd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 11;
    localparam int DIM_W     = 12;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN          = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET     = DIM_W'(480);
    localparam logic [DIM_W-1:0] WIDTH_LIMIT      = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT     = DIM_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_pos;

    // Saturates a programmed dimension to the range the line stores support.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_MIN) begin
            res = DIM_MIN;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

>>> rtl/lmpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module lmpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lmpd_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_pos: raster position tracker
// Resolves the column and row of the incoming pixel and advances on accept.
// ----------------------------------------------------------------------------
module lmpd_pos
    import lmpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_sof,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output t_pos             o_pos
);

    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] n_col;
    logic [COORD_W-1:0] n_row;
    logic [DIM_W-1:0]   cur_col;
    logic [DIM_W-1:0]   cur_row;
    logic [DIM_W-1:0]   nxt_col;
    logic [DIM_W-1:0]   nxt_row;

    always_comb begin
        cur_col = {1'b0, r_col};
        cur_row = {1'b0, r_row};
        if (i_sof) begin
            cur_col = '0;
            cur_row = '0;
        end
        // A shrunk geometry can leave the stored position outside the frame.
        if (cur_col >= i_width) begin
            cur_col = '0;
            cur_row = cur_row + DIM_W'(1);
        end
        if (cur_row >= i_height) begin
            cur_row = '0;
        end

        nxt_col = cur_col + DIM_W'(1);
        nxt_row = cur_row;
        if (nxt_col >= i_width) begin
            nxt_col = '0;
            nxt_row = cur_row + DIM_W'(1);
        end
        if (nxt_row >= i_height) begin
            nxt_row = '0;
        end

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            n_col = nxt_col[COORD_W-1:0];
            n_row = nxt_row[COORD_W-1:0];
        end

        o_pos.col = cur_col[COORD_W-1:0];
        o_pos.row = cur_row[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/lmpd_win.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpd_win: 3x3 window and local maximum test
// Shifts in one pixel column per load and tests the center against its ring.
// ----------------------------------------------------------------------------
module lmpd_win
    import lmpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [PIX_W-1:0] i_upper,
    input  logic [PIX_W-1:0] i_middle,
    input  logic [PIX_W-1:0] i_lower,
    output logic             o_peak,
    output logic [PIX_W-1:0] o_center
);

    // Index [column][row], column 0 is the oldest.
    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic             peak;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_win[i][j] = r_win[i+1][j];
            end
        end
        n_win[2][0] = i_upper;
        n_win[2][1] = i_middle;
        n_win[2][2] = i_lower;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_load) begin
            r_win <= n_win;
        end
    end

    // Equal neighbors do not suppress the center; only a strictly larger one does.
    always_comb begin
        peak = (r_win[1][1] != '0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_win[i][j] > r_win[1][1]) begin
                    peak = 1'b0;
                end
            end
        end
    end

    assign o_peak   = peak;
    assign o_center = r_win[1][1];

endmodule

>>> rtl/local_max_3x3_peak_detect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_max_3x3_peak_detect_core: streaming 3x3 local maximum detector
// Finds nonzero interior pixels with no strictly greater 3x3 neighbor in a
// raster pixel stream and reports their column, row and value.
// ----------------------------------------------------------------------------
// Output: a peak is captured in the result register when the transaction
// carrying its bottom-right neighbor leaves the window stage.
// Throughput: one pixel per cycle, sustained; only output back-pressure stalls
// the three-stage pipeline (line store read, window load, result register).
// Reset (synchronous, active low) clears the valids, counters and window and
// loads a 640 x 480 frame; the line stores are not cleared.
// ----------------------------------------------------------------------------
module local_max_3x3_peak_detect_core
    import lmpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Pixel input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_start_of_frame,
    // Peak output channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [COORD_W-1:0]   o_peak_x,
    output logic [COORD_W-1:0]   o_peak_y,
    output logic [PIX_W-1:0]     o_peak_value,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration. Dimensions are saturated when written, so the
    // datapath only ever sees a geometry the line stores can hold.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_width <= clamp_dim(i_cfg_data, WIDTH_LIMIT);
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= clamp_dim(i_cfg_data, HEIGHT_LIMIT);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when the one after it is empty
    // or moving. The result register doubles as the output holding stage,
    // so a waiting peak does not block new transactions until every stage
    // is full.
    // ------------------------------------------------------------------
    logic r_a_valid;
    logic r_w_valid;
    logic r_o_valid;
    logic out_free;
    logic w_free;
    logic a_free;
    logic a_go;
    logic w_go;
    logic accept;

    assign out_free = !r_o_valid || i_ready;
    assign w_go     = r_w_valid && out_free;
    assign w_free   = !r_w_valid || out_free;
    assign a_go     = r_a_valid && w_free;
    assign a_free   = !r_a_valid || w_free;
    assign o_ready  = a_free;
    assign accept   = i_valid && a_free;

    // ------------------------------------------------------------------
    // Position of the incoming pixel.
    // ------------------------------------------------------------------
    t_pos cur_pos;

    lmpd_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sof    (i_start_of_frame),
        .i_width  (r_width),
        .i_height (r_height),
        .o_pos    (cur_pos)
    );

    // ------------------------------------------------------------------
    // Stage A: the line stores are read at the pixel's column on accept.
    // The column is rewritten when the transaction leaves stage A: the
    // upper store takes the old middle row and the middle store takes the
    // new pixel. Only the transaction just behind can address the same
    // column in that cycle (two start-of-frame pixels in a row), and then
    // the written data is forwarded around the stores.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_a_pixel;
    t_pos             r_a_pos;
    logic             r_byp;
    logic [PIX_W-1:0] r_byp_upper;
    logic [PIX_W-1:0] r_byp_middle;
    logic [PIX_W-1:0] upper_q;
    logic [PIX_W-1:0] middle_q;
    logic [PIX_W-1:0] upper_pix;
    logic [PIX_W-1:0] middle_pix;
    logic             byp_hit;

    assign upper_pix  = r_byp ? r_byp_upper  : upper_q;
    assign middle_pix = r_byp ? r_byp_middle : middle_q;
    assign byp_hit    = a_go && (r_a_pos.col == cur_pos.col);

    lmpd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_upper (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_pos.col[ADDR_W-1:0]),
        .i_wdata (middle_pix),
        .i_re    (accept),
        .i_raddr (cur_pos.col[ADDR_W-1:0]),
        .o_rdata (upper_q)
    );

    lmpd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_middle (
        .i_clk   (i_clk),
        .i_we    (a_go),
        .i_waddr (r_a_pos.col[ADDR_W-1:0]),
        .i_wdata (r_a_pixel),
        .i_re    (accept),
        .i_raddr (cur_pos.col[ADDR_W-1:0]),
        .o_rdata (middle_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_byp     <= byp_hit;
            end else if (a_go) begin
                r_a_valid <= 1'b0;
                r_byp     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pixel    <= i_pixel;
            r_a_pos      <= cur_pos;
            r_byp_upper  <= middle_pix;
            r_byp_middle <= r_a_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Stage W: the window holds the neighborhood centered one column left
    // and one row up of the pixel that was loaded last.
    // ------------------------------------------------------------------
    t_pos             r_w_pos;
    logic             win_peak;
    logic [PIX_W-1:0] win_center;
    logic             cand;

    lmpd_win u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (a_go),
        .i_upper  (upper_pix),
        .i_middle (middle_pix),
        .i_lower  (r_a_pixel),
        .o_peak   (win_peak),
        .o_center (win_center)
    );

    // The center is interior only once the last loaded pixel is at column 2 and row 2 or beyond.
    assign cand = win_peak && (r_w_pos.col >= COORD_W'(2)) && (r_w_pos.row >= COORD_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (a_go) begin
            r_w_valid <= 1'b1;
        end else if (w_go) begin
            r_w_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_w_pos <= r_a_pos;
        end
    end

    // ------------------------------------------------------------------
    // Result register. Transactions with no peak are dropped here.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_peak_x;
    logic [COORD_W-1:0] r_peak_y;
    logic [PIX_W-1:0]   r_peak_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_go) begin
            r_o_valid <= cand;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && cand) begin
            r_peak_x     <= r_w_pos.col - COORD_W'(1);
            r_peak_y     <= r_w_pos.row - COORD_W'(1);
            r_peak_value <= win_center;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_peak_x     = r_peak_x;
    assign o_peak_y     = r_peak_y;
    assign o_peak_value = r_peak_value;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A reported peak is never on the left or top border and never zero.
    a_peak_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_x != '0) && (o_peak_y != '0) && (o_peak_value != '0))
        else $error("peak on border or with zero value");

    // A stalled stage A keeps its transaction.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_free) |=> r_a_valid)
        else $error("stage A lost a stalled transaction");

    // The forwarding path is only armed for a transaction in stage A.
    a_byp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> r_a_valid)
        else $error("line store forwarding armed without a transaction");

    // An accepted transaction always lands in stage A.
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted transaction did not enter stage A");

endmodule
